/* src/ptw_pkg.sv */
package ptw_pkg;

  localparam int unsigned TableFrames = 64;
  localparam int unsigned FrameW      = $clog2(TableFrames);
  localparam int unsigned SlotW       = 9;
  localparam int unsigned SlotCount   = 1 << SlotW;
  localparam int unsigned MemDepth    = TableFrames * SlotCount;
  localparam int unsigned AddrW       = FrameW + SlotW;
  localparam int unsigned NextW       = $clog2(TableFrames + 1);
  localparam int unsigned EntryW      = 64;
  localparam int unsigned PhysW       = 52;
  localparam int unsigned InDataW     = 184;
  localparam int unsigned OutDataW    = 120;

  localparam logic [EntryW-1:0] FrameMask = 64'h000F_FFFF_FFFF_F000;
  localparam int unsigned BitPresent  = 0;
  localparam int unsigned BitHuge     = 7;

  typedef enum logic [2:0] {
    ActMap       = 3'd0,
    ActUnmap     = 3'd1,
    ActResolve   = 3'd2,
    ActReadFlags = 3'd3,
    ActRewrite   = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StNoMem    = 2'd1,
    StMapped   = 2'd2,
    StNotFound = 2'd3
  } status_e;

  localparam logic CfgUserBoundary = 1'b0;
  localparam logic CfgTablesActive = 1'b1;

  typedef struct packed {
    logic    accept;
    logic    rd;
    logic    adv;
    logic    alloc;
    logic    clr;
    logic    wr;
    logic    wr_table;
    logic    res;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       present;
    logic       huge;
    logic       first;
    logic       leaf;
    logic       no_frame;
    logic       wvalid;
    logic       clr_last;
    logic       out_free;
  } sts_t;

endpackage

/* src/ptw_ram.sv */
module ptw_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/ptw_dp.sv */
module ptw_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ptw_pkg::cmd_t                 cmd_i,
  output ptw_pkg::sts_t                 sts_o,
  input  logic [ptw_pkg::InDataW-1:0]   in_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_index_i,
  input  logic [63:0]                   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptw_pkg::OutDataW-1:0]  out_data_o
);

  logic [2:0]                     action_q;
  logic [63:0]                    va_q;
  logic [ptw_pkg::PhysW-1:0]      pa_q;
  logic [63:0]                    flags_q;
  logic                           user_q;
  logic [1:0]                     lvl_q;
  logic [ptw_pkg::FrameW-1:0]     frame_q;
  logic [ptw_pkg::AddrW-1:0]      where_q;
  logic                           rd_valid_q;
  logic [ptw_pkg::TableFrames-1:0] valid_q;
  logic [ptw_pkg::NextW-1:0]      next_free_q;
  logic [ptw_pkg::SlotW-1:0]      cnt_q;
  logic [63:0]                    boundary_q;
  logic                           active_q;
  logic                           out_valid_q;
  logic [ptw_pkg::OutDataW-1:0]   out_data_q;

  logic [ptw_pkg::SlotW-1:0]      slot;
  logic [ptw_pkg::AddrW-1:0]      raddr;
  logic [ptw_pkg::AddrW-1:0]      waddr;
  logic [ptw_pkg::FrameW-1:0]     wframe;
  logic [63:0]                    rdata;
  logic [63:0]                    entry;
  logic [63:0]                    wr_data;
  logic [63:0]                    off;
  logic [63:0]                    xlat_full;
  logic                           ok;
  logic [ptw_pkg::PhysW-1:0]      xlat;
  logic [63:0]                    found;
  logic                           inval;

  always_comb begin
    case (lvl_q)
      2'd0:    slot = va_q[47:39];
      2'd1:    slot = va_q[38:30];
      2'd2:    slot = va_q[29:21];
      default: slot = va_q[20:12];
    endcase
  end

  assign raddr  = {frame_q, slot};
  assign wframe = where_q[ptw_pkg::AddrW-1 -: ptw_pkg::FrameW];
  assign waddr  = cmd_i.clr ? {wframe, cnt_q} : where_q;
  assign entry  = rd_valid_q ? rdata : 64'd0;

  always_comb begin
    if (cmd_i.wr_table) begin
      wr_data = {{(64 - 12 - ptw_pkg::FrameW){1'b0}}, frame_q, 12'h000}
                | {61'd0, user_q, 2'b11};
    end else begin
      case (action_q)
        ptw_pkg::ActMap:     wr_data = {12'd0, pa_q[51:12], 12'h000}
                                       | (flags_q & ~ptw_pkg::FrameMask) | 64'd1;
        ptw_pkg::ActRewrite: wr_data = (entry & ptw_pkg::FrameMask)
                                       | (flags_q & ~ptw_pkg::FrameMask) | 64'd1;
        default:             wr_data = 64'd0;
      endcase
    end
  end

  ptw_ram #(
    .Width (ptw_pkg::EntryW),
    .Depth (ptw_pkg::MemDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr | cmd_i.wr),
    .waddr_i (waddr),
    .wdata_i (cmd_i.clr ? 64'd0 : wr_data),
    .re_i    (cmd_i.rd),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // page offset follows the level that ended the walk
  always_comb begin
    case (lvl_q)
      2'd1:    off = 64'h0000_0000_3FFF_FFFF;
      2'd2:    off = 64'h0000_0000_001F_FFFF;
      default: off = 64'h0000_0000_0000_0FFF;
    endcase
  end

  assign xlat_full = (entry & ptw_pkg::FrameMask & ~off) | (va_q & off);
  assign ok        = cmd_i.status == ptw_pkg::StOk;
  assign xlat      = (ok && action_q == ptw_pkg::ActResolve) ?
                     xlat_full[ptw_pkg::PhysW-1:0] : '0;
  assign found     = (ok && action_q == ptw_pkg::ActReadFlags) ?
                     (entry & ~ptw_pkg::FrameMask) : 64'd0;
  assign inval     = active_q && ok && (action_q == ptw_pkg::ActMap ||
                     action_q == ptw_pkg::ActUnmap || action_q == ptw_pkg::ActRewrite);

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= in_data_i[2:0];
      va_q     <= in_data_i[66:3];
      pa_q     <= in_data_i[118:67];
      flags_q  <= in_data_i[182:119];
      user_q   <= {in_data_i[66:15], 12'h000} < boundary_q;
    end
    if (cmd_i.rd) begin
      where_q <= raddr;
    end
    if (cmd_i.res) begin
      out_data_q <= {1'b0, inval, found, xlat, cmd_i.status};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q       <= '0;
      frame_q     <= '0;
      rd_valid_q  <= 1'b0;
      valid_q     <= '0;
      next_free_q <= ptw_pkg::NextW'(1);
      cnt_q       <= '0;
      boundary_q  <= 64'hFFFF_FFFF_8000_0000;
      active_q    <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        lvl_q   <= '0;
        frame_q <= '0;
      end
      if (cmd_i.rd) begin
        rd_valid_q <= valid_q[frame_q];
      end
      if (cmd_i.adv) begin
        frame_q <= entry[12 +: ptw_pkg::FrameW];
        lvl_q   <= lvl_q + 2'd1;
      end
      // a fresh table reads as zero until its frame is swept
      if (cmd_i.alloc) begin
        frame_q     <= next_free_q[ptw_pkg::FrameW-1:0];
        lvl_q       <= lvl_q + 2'd1;
        next_free_q <= next_free_q + ptw_pkg::NextW'(1);
        valid_q[next_free_q[ptw_pkg::FrameW-1:0]] <= 1'b0;
      end
      if (cmd_i.clr) begin
        cnt_q <= cnt_q + ptw_pkg::SlotW'(1);
        if (&cnt_q) begin
          valid_q[wframe] <= 1'b1;
        end
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          ptw_pkg::CfgUserBoundary: boundary_q <= cfg_data_i;
          ptw_pkg::CfgTablesActive: active_q   <= cfg_data_i[0];
          default:                  active_q   <= active_q;
        endcase
      end
      if (cmd_i.res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.action   = action_q;
  assign sts_o.present  = entry[ptw_pkg::BitPresent];
  assign sts_o.huge     = entry[ptw_pkg::BitHuge];
  assign sts_o.first    = lvl_q == 2'd0;
  assign sts_o.leaf     = lvl_q == 2'd3;
  assign sts_o.no_frame = next_free_q >= ptw_pkg::NextW'(ptw_pkg::TableFrames);
  assign sts_o.wvalid   = valid_q[wframe];
  assign sts_o.clr_last = &cnt_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* src/ptw_ctrl.sv */
module ptw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ptw_pkg::sts_t sts_i,
  output ptw_pkg::cmd_t cmd_o
);

  typedef enum logic [6:0] {
    SIdle  = 7'b0000001,
    SRead  = 7'b0000010,
    SEval  = 7'b0000100,
    SCheck = 7'b0001000,
    SClear = 7'b0010000,
    SWrite = 7'b0100000,
    SDone  = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  ptw_pkg::status_e st_q, st_d;
  logic             kind_q, kind_d;

  always_comb begin
    state_d    = state_q;
    st_d       = st_q;
    kind_d     = kind_q;
    cmd_o      = '0;
    cmd_o.status = st_q;
    cmd_o.wr_table = kind_q;
    in_ready_o = state_q == SIdle;
    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = SRead;
        end
      end
      SRead: begin
        cmd_o.rd = 1'b1;
        state_d = SEval;
      end
      SEval: begin
        if (sts_i.leaf || (sts_i.huge && !sts_i.first)) begin
          state_d = SDone;
          case (sts_i.action)
            ptw_pkg::ActMap: begin
              if (sts_i.present) begin
                st_d = ptw_pkg::StMapped;
              end else begin
                kind_d  = 1'b0;
                state_d = SCheck;
              end
            end
            ptw_pkg::ActUnmap, ptw_pkg::ActRewrite: begin
              if (!sts_i.present) begin
                st_d = ptw_pkg::StNotFound;
              end else begin
                kind_d  = 1'b0;
                state_d = SCheck;
              end
            end
            ptw_pkg::ActResolve: begin
              st_d = sts_i.present ? ptw_pkg::StOk : ptw_pkg::StNotFound;
            end
            ptw_pkg::ActReadFlags: begin
              st_d = ptw_pkg::StOk;
            end
            default: begin
              st_d = ptw_pkg::StNotFound;
            end
          endcase
        end else if (!sts_i.present) begin
          if (sts_i.action != ptw_pkg::ActMap) begin
            st_d    = ptw_pkg::StNotFound;
            state_d = SDone;
          end else if (sts_i.no_frame) begin
            st_d    = ptw_pkg::StNoMem;
            state_d = SDone;
          end else begin
            cmd_o.alloc = 1'b1;
            kind_d  = 1'b1;
            state_d = SCheck;
          end
        end else begin
          cmd_o.adv = 1'b1;
          state_d = SRead;
        end
      end
      SCheck: begin
        state_d = sts_i.wvalid ? SWrite : SClear;
      end
      SClear: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = SWrite;
        end
      end
      SWrite: begin
        cmd_o.wr = 1'b1;
        if (kind_q) begin
          state_d = SRead;
        end else begin
          st_d    = ptw_pkg::StOk;
          state_d = SDone;
        end
      end
      SDone: begin
        if (sts_i.out_free) begin
          cmd_o.res = 1'b1;
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      st_q    <= ptw_pkg::StOk;
      kind_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      kind_q  <= kind_d;
    end
  end

endmodule

/* src/four_level_page_table_engine.sv */
// Four-level page-table walker over a pool of 64 frames of 512 entries, frame zero the
// root. One request at a time: each table level takes a read and a decide step, a
// write adds a check and a write step, and the first write into a frame that was never
// cleared (after reset, or a newly created table) first sweeps that frame at one
// entry per cycle. The result sits in an output register, so the next request is
// taken once the result is loaded. Configuration index 0 is the user boundary, index 1
// tables_active.
module four_level_page_table_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action, virtual_address, physical_address, entry_flags
  input  logic [ptw_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, translated_address, found_flags, invalidate
  output logic [ptw_pkg::OutDataW-1:0]  m_axis_tdata,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  ptw_pkg::cmd_t cmd;
  ptw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  ptw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ptw_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken while walk in progress");

  a_write_cleared_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wr |-> sts.wvalid)
    else $error("entry write into uncleared frame");

  a_inval_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[118] |-> m_axis_tdata[1:0] == ptw_pkg::StOk)
    else $error("invalidate on failed request");
`endif

endmodule

/* test/tb_four_level_page_table_engine.sv */
`timescale 1ns / 1ps

module tb_four_level_page_table_engine;
  import ptw_pkg::*;

  typedef struct {
    logic [2:0]  action;
    logic [63:0] vaddr;
    logic [51:0] paddr;
    logic [63:0] flags;
    int          gap;
  } pt_request_t;

  typedef struct {
    logic [1:0]  status;
    logic [51:0] xlat;
    logic [63:0] found;
    logic        inval;
  } pt_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic                cfg_index_i;
  logic [63:0]         cfg_data_i;

  logic [63:0] pt_mem [MemDepth];
  int          next_free;
  logic [63:0] user_boundary;
  logic        tables_active;

  pt_request_t pending_reqs[$];
  pt_result_t  expected_results[$];
  pt_request_t cur_req;
  bit          have_req;
  int          send_wait;
  bit          req_taken;
  bit          rsp_taken;
  int          rx_wait;
  int          rx_hold;
  int          result_count;
  int          mismatch_count;
  bit          calm;

  four_level_page_table_engine u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic status_e walk_tables(input logic [63:0] va, input bit create,
                                          output int where, output int level);
    logic [63:0] tflags;
    int frame;
    int at;
    int shift;
    int f;
    tflags = 64'h3;
    if (va < user_boundary) tflags |= 64'h4;
    frame = 0;
    where = 0;
    level = 1;
    for (int i = 0; i < 3; i++) begin
      shift = (i == 0) ? 39 : (i == 1) ? 30 : 21;
      at = frame * SlotCount + int'((va >> shift) & 64'h1ff);
      if (i > 0 && pt_mem[at][BitHuge]) begin
        where = at;
        level = 4 - i;
        return StOk;
      end
      if (!pt_mem[at][BitPresent]) begin
        if (!create) return StNotFound;
        if (next_free >= TableFrames) return StNoMem;
        f = next_free;
        next_free++;
        for (int k = 0; k < SlotCount; k++) pt_mem[f * SlotCount + k] = '0;
        pt_mem[at] = ((64'(f) << 12) & FrameMask) | tflags | 64'h1;
        frame = f;
      end else begin
        frame = int'(pt_mem[at][51:12] % TableFrames);
      end
    end
    where = frame * SlotCount + int'(va[20:12]);
    level = 1;
    return StOk;
  endfunction

  function automatic pt_result_t apply_request(input pt_request_t r);
    pt_result_t res;
    status_e st;
    int where;
    int level;
    logic [63:0] entry;
    logic [63:0] off;
    logic [63:0] va_al;
    res = '{StOk, '0, '0, 1'b0};
    va_al = {r.vaddr[63:12], 12'h000};
    entry = {12'h000, r.paddr[51:12], 12'h000} | (r.flags & ~FrameMask) | 64'h1;
    case (r.action)
      ActMap: begin
        st = walk_tables(va_al, 1'b1, where, level);
        if (st != StOk) res.status = StNoMem;
        else if (pt_mem[where][BitPresent]) res.status = StMapped;
        else begin
          pt_mem[where] = entry;
          res.inval = tables_active;
        end
      end
      ActUnmap: begin
        st = walk_tables(va_al, 1'b0, where, level);
        if (st != StOk || !pt_mem[where][BitPresent]) res.status = StNotFound;
        else begin
          pt_mem[where] = '0;
          res.inval = tables_active;
        end
      end
      ActResolve: begin
        st = walk_tables(r.vaddr, 1'b0, where, level);
        if (st != StOk || !pt_mem[where][BitPresent]) res.status = StNotFound;
        else begin
          off = (level == 3) ? 64'h3FFF_FFFF : (level == 2) ? 64'h1F_FFFF : 64'hFFF;
          res.xlat = 52'((pt_mem[where] & FrameMask & ~off) | (r.vaddr & off));
        end
      end
      ActReadFlags: begin
        st = walk_tables(r.vaddr, 1'b0, where, level);
        if (st != StOk) res.status = StNotFound;
        else res.found = pt_mem[where] & ~FrameMask;
      end
      ActRewrite: begin
        st = walk_tables(r.vaddr, 1'b0, where, level);
        if (st != StOk || !pt_mem[where][BitPresent]) res.status = StNotFound;
        else begin
          pt_mem[where] = (pt_mem[where] & FrameMask) | (r.flags & ~FrameMask) | 64'h1;
          res.inval = tables_active;
        end
      end
      default: res.status = StNotFound;
    endcase
    return res;
  endfunction

  // request driver
  always @(negedge clk_i) begin
    logic nv;
    nv = s_axis_tvalid;
    if (req_taken) begin
      req_taken = 1'b0;
      nv = 1'b0;
    end
    if (!nv) begin
      if (!have_req && pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        send_wait = cur_req.gap;
        have_req = 1'b1;
      end
      if (have_req) begin
        if (send_wait > 0) send_wait--;
        else begin
          s_axis_tdata <= {1'b0, cur_req.flags, cur_req.paddr, cur_req.vaddr, cur_req.action};
          have_req = 1'b0;
          nv = 1'b1;
        end
      end
    end
    s_axis_tvalid <= nv;
  end

  // result receiver
  always @(negedge clk_i) begin
    logic nr;
    nr = 1'b1;
    if (rsp_taken) begin
      rsp_taken = 1'b0;
      rx_wait = ((result_count / 64) % 3 == 0) ? 0 : $urandom_range(0, 5);
      if (result_count == 300) rx_hold = 400;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      nr = 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      nr = 1'b0;
    end
    m_axis_tready <= nr;
  end

  // monitor
  always @(posedge clk_i) begin
    pt_request_t r;
    pt_result_t exp_r;
    pt_result_t got;
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      r.action = s_axis_tdata[2:0];
      r.vaddr  = s_axis_tdata[66:3];
      r.paddr  = s_axis_tdata[118:67];
      r.flags  = s_axis_tdata[182:119];
      r.gap    = 0;
      expected_results.push_back(apply_request(r));
      req_taken = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status = m_axis_tdata[1:0];
      got.xlat   = m_axis_tdata[53:2];
      got.found  = m_axis_tdata[117:54];
      got.inval  = m_axis_tdata[118];
      rsp_taken = 1'b1;
      result_count++;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %h", m_axis_tdata);
      end else begin
        exp_r = expected_results.pop_front();
        if (got.status !== exp_r.status || got.xlat !== exp_r.xlat ||
            got.found !== exp_r.found || got.inval !== exp_r.inval) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch #%0d: exp st=%0d xlat=%h flags=%h inv=%b, got st=%0d xlat=%h flags=%h inv=%b",
                     result_count, exp_r.status, exp_r.xlat, exp_r.found, exp_r.inval,
                     got.status, got.xlat, got.found, got.inval);
        end
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [63:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    forever begin
      @(posedge clk_i);
      if (cfg_ready_o) break;
    end
    if (idx == CfgUserBoundary) user_boundary = value;
    else tables_active = value[0];
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_reqs.size() > 0 || have_req || s_axis_tvalid ||
           expected_results.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic queue_req(input logic [2:0] act, input logic [63:0] va,
                           input logic [51:0] pa, input logic [63:0] fl);
    pt_request_t r;
    r.action = act;
    r.vaddr  = va;
    r.paddr  = pa;
    r.flags  = fl;
    r.gap    = calm ? 0 : $urandom_range(0, 5);
    pending_reqs.push_back(r);
  endtask

  function automatic logic [63:0] pick_vaddr();
    logic [15:0] hi;
    logic [8:0]  l4;
    logic [8:0]  l3;
    logic [8:0]  l2;
    logic [8:0]  l1;
    if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
    case ($urandom_range(0, 2))
      0: hi = 16'h0000;
      1: hi = 16'hFFFF;
      default: hi = 16'($urandom);
    endcase
    case ($urandom_range(0, 3))
      0: l4 = 9'd0;
      1: l4 = 9'd1;
      2: l4 = 9'd256;
      default: l4 = 9'd511;
    endcase
    l3 = ($urandom_range(0, 1) == 0) ? 9'($urandom_range(0, 1)) : 9'($urandom_range(510, 511));
    l2 = 9'($urandom_range(0, 3) * 170);
    l1 = ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 7));
    return {hi, l4, l3, l2, l1, 12'($urandom)};
  endfunction

  task automatic queue_random(input int count);
    int sel;
    logic [2:0] act;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 32) act = ActMap;
      else if (sel < 46) act = ActUnmap;
      else if (sel < 70) act = ActResolve;
      else if (sel < 84) act = ActReadFlags;
      else if (sel < 97) act = ActRewrite;
      else act = 3'($urandom_range(5, 7));
      queue_req(act, pick_vaddr(), 52'({$urandom, $urandom}), {$urandom, $urandom});
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = 1'b0;
    cfg_data_i    = '0;
    for (int k = 0; k < MemDepth; k++) pt_mem[k] = '0;
    next_free     = 1;
    user_boundary = 64'hFFFF_FFFF_8000_0000;
    tables_active = 1'b1;
    calm          = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_reg(CfgUserBoundary, 64'hFFFF_FFFF_8000_0000);
    write_reg(CfgTablesActive, 64'd1);
    queue_req(ActResolve, 64'h0, '0, '0);
    queue_req(ActReadFlags, 64'h0, '0, '0);
    queue_req(ActUnmap, 64'h0, '0, '0);
    queue_req(ActRewrite, 64'h0, '0, '1);
    queue_req(3'd5, 64'h0, '0, '0);
    queue_req(3'd7, '1, '1, '1);
    queue_req(ActMap, 64'h0, '1, '1);
    queue_req(ActMap, 64'h0FFF, 52'h1000, '0);
    queue_req(ActResolve, 64'h0FFF, '0, '0);
    queue_req(ActReadFlags, 64'h0, '0, '0);
    queue_req(ActRewrite, 64'h0, '0, '0);
    queue_req(ActReadFlags, 64'h0, '0, '0);
    queue_req(ActResolve, 64'h0ABC, '0, '0);
    queue_req(ActUnmap, 64'h0123, '0, '0);
    queue_req(ActReadFlags, 64'h0, '0, '0);
    queue_req(ActResolve, 64'h0, '0, '0);
    queue_req(ActMap, '1, '0, '0);
    queue_req(ActResolve, '1, '0, '0);
    queue_req(ActMap, 64'hFFFF_FFFF_7FFF_FFFF, 52'hABCDE_F012_3456, 64'h8000_0000_0000_0086);
    queue_req(ActReadFlags, 64'hFFFF_FFFF_7FFF_F000, '0, '0);
    queue_req(ActRewrite, '1, '0, '1);
    queue_req(ActReadFlags, '1, '0, '0);
    wait_idle();

    write_reg(CfgUserBoundary, 64'h0);
    write_reg(CfgTablesActive, 64'd0);
    queue_random(300);
    wait_idle();

    write_reg(CfgUserBoundary, '1);
    write_reg(CfgTablesActive, 64'd1);
    queue_random(300);
    wait_idle();

    write_reg(CfgUserBoundary, {$urandom, $urandom});
    write_reg(CfgTablesActive, 64'($urandom_range(0, 1)));
    queue_random(330);
    wait_idle();

    repeat (50) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
